// ===== src/bva_pkg.sv =====
// Shared types and constants for the button volume auto-repeat block.
`timescale 1ns / 1ps

package bva_pkg;

    localparam int LEVEL_W    = 7;
    localparam int DELAY_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int EV_MAX     = 4;
    localparam int EV_IDX_W   = 2;
    localparam int EV_CNT_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [EV_CNT_W-1:0] EV_CNT_MAX = EV_CNT_W'(EV_MAX);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOUDEST     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIETEST    = 2'd2;

    localparam logic [DELAY_W-1:0] PRESS_DELAY_RST = 16'd250;
    localparam logic [LEVEL_W-1:0] LOUDEST_RST     = 7'd0;
    localparam logic [LEVEL_W-1:0] QUIETEST_RST    = 7'd79;

    typedef enum logic [1:0] {
        EV_LEVEL = 2'd0,
        EV_SAVE  = 2'd1,
        EV_MUTE  = 2'd2
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t             kind;
        logic [LEVEL_W-1:0]   value;
    } ev_t;

    typedef struct packed {
        logic up;
        logic down;
        logic mute;
    } buttons_t;

    typedef struct packed {
        logic [DELAY_W-1:0] press_delay;
        logic [LEVEL_W-1:0] loudest;
        logic [LEVEL_W-1:0] quietest;
    } cfg_t;

endpackage

// ===== src/bva_core.sv =====
// Per-sample button logic and the volume, mute, repeat and hold-off state.
`timescale 1ns / 1ps

module bva_core
    import bva_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  buttons_t              btn,
    input  logic [TIME_WIDTH-1:0] now,
    input  cfg_t                  cfg,
    output ev_t                   evs [EV_MAX],
    output logic [EV_CNT_W-1:0]   ev_count
);

    buttons_t              prev_reg,         prev_next;
    logic [TIME_WIDTH-1:0] repeat_start_reg, repeat_start_next;
    logic                  auto_up_reg,      auto_up_next;
    logic                  auto_down_reg,    auto_down_next;
    logic [LEVEL_W-1:0]    level_reg,        level_next;
    logic                  mute_reg,         mute_next;
    logic                  holdoff_reg,      holdoff_next;
    logic [TIME_WIDTH-1:0] holdoff_start_reg, holdoff_start_next;

    always_comb
    begin
        logic [TIME_WIDTH-1:0] delay;
        logic [TIME_WIDTH-1:0] elapsed;
        logic [EV_CNT_W-1:0]   n;
        logic                  save;
        logic                  released;

        delay    = TIME_WIDTH'(cfg.press_delay);
        elapsed  = '0;
        n        = '0;
        save     = 1'b0;
        released = 1'b0;

        for (int i = 0; i < EV_MAX; i++)
        begin
            evs[i] = '{kind: EV_LEVEL, value: '0};
        end

        prev_next          = btn;
        repeat_start_next  = repeat_start_reg;
        auto_up_next       = auto_up_reg;
        auto_down_next     = auto_down_reg;
        level_next         = level_reg;
        mute_next          = mute_reg;
        holdoff_next       = holdoff_reg;
        holdoff_start_next = holdoff_start_reg;

        // Inside the hold-off window only the previous levels follow the sample
        if (!(holdoff_reg && ((now - holdoff_start_reg) < delay)))
        begin
            holdoff_next = 1'b0;

            if ((prev_reg.up && !btn.up) || (prev_reg.down && !btn.down))
            begin
                repeat_start_next = now;
            end

            elapsed = now - repeat_start_next;
            if (!btn.up && (elapsed > delay))
            begin
                repeat_start_next = now;
                if (level_next > cfg.loudest)
                begin
                    level_next   = level_next - 1'b1;
                    auto_up_next = 1'b1;
                    if (n < EV_CNT_MAX)
                    begin
                        evs[n[EV_IDX_W-1:0]] = '{kind: EV_LEVEL, value: level_next};
                        n = n + 1'b1;
                    end
                end
            end

            // Judged against the timer as the up repeat left it
            elapsed = now - repeat_start_next;
            if (!btn.down && (elapsed > delay))
            begin
                repeat_start_next = now;
                if (level_next < cfg.quietest)
                begin
                    level_next     = level_next + 1'b1;
                    auto_down_next = 1'b1;
                    if (n < EV_CNT_MAX)
                    begin
                        evs[n[EV_IDX_W-1:0]] = '{kind: EV_LEVEL, value: level_next};
                        n = n + 1'b1;
                    end
                end
            end

            if (!prev_reg.up && btn.up)
            begin
                if (auto_up_next)
                begin
                    auto_up_next = 1'b0;
                    save         = 1'b1;
                end
                else if (level_next > cfg.loudest)
                begin
                    level_next = level_next - 1'b1;
                    save       = 1'b1;
                    if (n < EV_CNT_MAX)
                    begin
                        evs[n[EV_IDX_W-1:0]] = '{kind: EV_LEVEL, value: level_next};
                        n = n + 1'b1;
                    end
                end
                released = 1'b1;
            end

            if (!prev_reg.down && btn.down)
            begin
                if (auto_down_next)
                begin
                    auto_down_next = 1'b0;
                    save           = 1'b1;
                end
                else if (level_next < cfg.quietest)
                begin
                    level_next = level_next + 1'b1;
                    save       = 1'b1;
                    if (n < EV_CNT_MAX)
                    begin
                        evs[n[EV_IDX_W-1:0]] = '{kind: EV_LEVEL, value: level_next};
                        n = n + 1'b1;
                    end
                end
                released = 1'b1;
            end

            // One save request covers both releases
            if (save && (n < EV_CNT_MAX))
            begin
                evs[n[EV_IDX_W-1:0]] = '{kind: EV_SAVE, value: level_next};
                n = n + 1'b1;
            end

            if (!prev_reg.mute && btn.mute)
            begin
                mute_next = !mute_reg;
                if (n < EV_CNT_MAX)
                begin
                    evs[n[EV_IDX_W-1:0]] = '{kind: EV_MUTE,
                                             value: LEVEL_W'(mute_next)};
                    n = n + 1'b1;
                end
                released = 1'b1;
            end

            if (released)
            begin
                holdoff_next       = 1'b1;
                holdoff_start_next = now;
            end
        end

        ev_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg          <= '{up: 1'b1, down: 1'b1, mute: 1'b1};
            repeat_start_reg  <= '0;
            auto_up_reg       <= 1'b0;
            auto_down_reg     <= 1'b0;
            level_reg         <= QUIETEST_RST;
            mute_reg          <= 1'b0;
            holdoff_reg       <= 1'b0;
            holdoff_start_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg          <= prev_next;
            repeat_start_reg  <= repeat_start_next;
            auto_up_reg       <= auto_up_next;
            auto_down_reg     <= auto_down_next;
            level_reg         <= level_next;
            mute_reg          <= mute_next;
            holdoff_reg       <= holdoff_next;
            holdoff_start_reg <= holdoff_start_next;
        end
    end

endmodule

// ===== src/bva_evq.sv =====
// Result buffer: holds a sample's events, handing out one per cycle unless stalled.
`timescale 1ns / 1ps

module bva_evq
    import bva_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ev_t                 evs [EV_MAX],
    input  logic [EV_CNT_W-1:0] ev_count,
    output logic                load_ok,
    output logic                event_valid,
    input  logic                event_stall,
    output ev_t                 head,
    output logic                head_last
);

    ev_t                 ev_reg [EV_MAX];
    logic [EV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                take;

    assign event_valid = (cnt_reg != '0);
    assign take        = event_valid && !event_stall;
    assign load_ok     = (cnt_reg == '0) || ((cnt_reg == EV_CNT_W'(1)) && take);
    assign head        = ev_reg[0];
    assign head_last   = (cnt_reg == EV_CNT_W'(1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = ev_count;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload: load a new list, or advance the list on each taken request
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < EV_MAX; i++)
            begin
                ev_reg[i] <= evs[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < EV_MAX - 1; i++)
            begin
                ev_reg[i] <= ev_reg[i + 1];
            end
        end
    end

endmodule

// ===== src/button_volume_autorepeat.sv =====
// Top level: sample register, configuration registers, core and result buffer.
//
// Button volume control with auto-repeat.
// Sample channel: up_level, down_level, mute_level (active low) and now_ms, taken
// at an edge where sample_valid is high and sample_stall is low.
// Event channel: event_kind, event_value, last_event, handed over at an edge
// where event_valid is high and event_stall is low; last_event marks the final
// event of a sample. A sample causes zero to four events.
// Order: a taken sample waits in the input register until the result buffer is
// free; its events are then loaded into the buffer, which shows the first one.
// Throughput: one sample per cycle while samples cause at most one event and
// event_stall is low; a sample with more events holds the single event port
// until its last event is taken, and the next sample waits for it.
// Stall: while event_stall is high the buffer holds its events, the waiting
// sample stays in the input register and sample_stall rises; no event is lost.
// Reset: level 79, mute off, no hold-off, delay 250 ms, limits 0 and 79.
// Configuration: wr_en, wr_index, wr_data write the delay (0), loudest limit (1)
// and quietest limit (2); other indexes are ignored. Write only while idle.
`timescale 1ns / 1ps

module button_volume_autorepeat
    import bva_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic                 up_level,
    input  logic                 down_level,
    input  logic                 mute_level,
    input  logic [STAMP_W-1:0]   now_ms,
    output logic                 event_valid,
    input  logic                 event_stall,
    output logic [1:0]           event_kind,
    output logic [LEVEL_W-1:0]   event_value,
    output logic                 last_event,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DELAY_W-1:0]   wr_data
);

    logic                  in_valid_reg;
    buttons_t              btn_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    cfg_t                  cfg_reg;
    logic                  load_ok;
    logic                  advance;
    logic                  accept;
    ev_t                   evs [EV_MAX];
    logic [EV_CNT_W-1:0]   ev_count;
    ev_t                   head;

    assign advance      = in_valid_reg && load_ok;
    assign sample_stall = in_valid_reg && !load_ok;
    assign accept       = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            btn_reg <= '{up: up_level, down: down_level, mute: mute_level};
            now_reg <= TIME_WIDTH'(now_ms);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{press_delay: PRESS_DELAY_RST,
                         loudest:     LOUDEST_RST,
                         quietest:    QUIETEST_RST};
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_PRESS_DELAY: cfg_reg.press_delay <= wr_data;
                CFG_LOUDEST:     cfg_reg.loudest     <= wr_data[LEVEL_W-1:0];
                CFG_QUIETEST:    cfg_reg.quietest    <= wr_data[LEVEL_W-1:0];
                default:         ;
            endcase
        end
    end

    bva_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .btn      (btn_reg),
        .now      (now_reg),
        .cfg      (cfg_reg),
        .evs      (evs),
        .ev_count (ev_count)
    );

    bva_evq u_evq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .evs         (evs),
        .ev_count    (ev_count),
        .load_ok     (load_ok),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .head        (head),
        .head_last   (last_event)
    );

    assign event_kind  = head.kind;
    assign event_value = head.value;

endmodule

// ===== test/tb_button_volume_autorepeat.sv =====
// Testbench for button_volume_autorepeat: directed table plus random button sequences.
`timescale 1ns / 1ps

module tb_button_volume_autorepeat;
    import bva_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int PHASES           = 4;
    localparam int DIRECTED_ROWS    = 21;

    typedef struct {
        ev_kind_t           kind;
        logic [LEVEL_W-1:0] value;
        logic               is_last;
    } vol_event_t;

    typedef struct packed {
        logic               up;
        logic               down;
        logic               mute;
        logic [STAMP_W-1:0] stamp;
        logic               typed;
        logic [2:0]         count;
        ev_kind_t           kind;
        logic [LEVEL_W-1:0] value;
    } sample_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    logic                 up_level;
    logic                 down_level;
    logic                 mute_level;
    logic [STAMP_W-1:0]   now_ms;
    logic                 event_valid;
    logic                 event_stall;
    logic [1:0]           event_kind;
    logic [LEVEL_W-1:0]   event_value;
    logic                 last_event;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [DELAY_W-1:0]   wr_data;

    // predictor copy of the block state and registers
    logic                 held_up;
    logic                 held_down;
    logic                 held_mute;
    logic [STAMP_W-1:0]   repeat_stamp;
    logic                 auto_up;
    logic                 auto_down;
    logic [LEVEL_W-1:0]   level;
    logic                 muted;
    logic                 holdoff_on;
    logic [STAMP_W-1:0]   holdoff_stamp;
    logic [DELAY_W-1:0]   delay_ms;
    logic [LEVEL_W-1:0]   loud_lim;
    logic [LEVEL_W-1:0]   quiet_lim;

    vol_event_t           pending_events[$];
    vol_event_t           want;
    int                   mismatches;
    int                   samples_sent;
    int                   events_seen;
    int                   cycles;
    int                   last_count;
    ev_kind_t             first_kind;
    logic [LEVEL_W-1:0]   first_value;
    logic [STAMP_W-1:0]   now_t;
    int                   no_gap_left;
    int                   stall_left;
    int                   run_left;

    sample_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, 1'b1, 1'b1, 32'd1000, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b0, 1'b1, 1'b1, 32'd1010, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'd1020, 1'b1, 3'd2, EV_LEVEL, 7'd78},
        '{1'b1, 1'b0, 1'b1, 32'd1100, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'd1200, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b0, 32'd1270, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'd1280, 1'b1, 3'd1, EV_MUTE,  7'd1},
        '{1'b1, 1'b0, 1'b1, 32'd1600, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b0, 1'b1, 32'd1851, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b0, 1'b1, 32'd2200, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'd2210, 1'b1, 3'd1, EV_SAVE,  7'd79},
        '{1'b0, 1'b0, 1'b1, 32'd2500, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b0, 1'b0, 1'b1, 32'd2800, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b0, 1'b0, 1'b1, 32'd3100, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b0, 32'd3101, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'd3400, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b0, 1'b1, 1'b1, 32'hFFFF_FF00, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b0, 1'b1, 1'b1, 32'h0000_0010, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'h0000_0020, 1'b0, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 3'd0, EV_LEVEL, 7'd0},
        '{1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 3'd0, EV_LEVEL, 7'd0}
    };

    button_volume_autorepeat dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .up_level     (up_level),
        .down_level   (down_level),
        .mute_level   (mute_level),
        .now_ms       (now_ms),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .event_value  (event_value),
        .last_event   (last_event),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Work out the events one button sample causes and queue them in order.
    task automatic predict_events(input logic up, input logic down, input logic mute,
                                  input logic [STAMP_W-1:0] stamp);
        ev_kind_t           kinds [EV_MAX];
        logic [LEVEL_W-1:0] vals [EV_MAX];
        logic [STAMP_W-1:0] elapsed;
        logic               save;
        logic               released;
        int                 n;
        n = 0;
        save = 1'b0;
        released = 1'b0;
        if (holdoff_on) begin
            elapsed = stamp - holdoff_stamp;
            if (elapsed < STAMP_W'(delay_ms)) begin
                held_up = up;
                held_down = down;
                held_mute = mute;
                last_count = 0;
                return;
            end
            holdoff_on = 1'b0;
        end
        if ((held_up && !up) || (held_down && !down))
            repeat_stamp = stamp;
        elapsed = stamp - repeat_stamp;
        if (!up && elapsed > STAMP_W'(delay_ms)) begin
            repeat_stamp = stamp;
            if (level > loud_lim) begin
                level--;
                kinds[n] = EV_LEVEL;
                vals[n] = level;
                n++;
                auto_up = 1'b1;
            end
        end
        // judged against the timer as just updated
        elapsed = stamp - repeat_stamp;
        if (!down && elapsed > STAMP_W'(delay_ms)) begin
            repeat_stamp = stamp;
            if (level < quiet_lim) begin
                level++;
                kinds[n] = EV_LEVEL;
                vals[n] = level;
                n++;
                auto_down = 1'b1;
            end
        end
        if (!held_up && up) begin
            if (auto_up) begin
                auto_up = 1'b0;
                save = 1'b1;
            end
            else if (level > loud_lim) begin
                level--;
                kinds[n] = EV_LEVEL;
                vals[n] = level;
                n++;
                save = 1'b1;
            end
            released = 1'b1;
        end
        if (!held_down && down) begin
            if (auto_down) begin
                auto_down = 1'b0;
                save = 1'b1;
            end
            else if (level < quiet_lim) begin
                level++;
                kinds[n] = EV_LEVEL;
                vals[n] = level;
                n++;
                save = 1'b1;
            end
            released = 1'b1;
        end
        if (save && n < EV_MAX) begin
            kinds[n] = EV_SAVE;
            vals[n] = level;
            n++;
        end
        if (!held_mute && mute) begin
            muted = !muted;
            if (n < EV_MAX) begin
                kinds[n] = EV_MUTE;
                vals[n] = LEVEL_W'(muted);
                n++;
            end
            released = 1'b1;
        end
        if (released) begin
            holdoff_on = 1'b1;
            holdoff_stamp = stamp;
        end
        held_up = up;
        held_down = down;
        held_mute = mute;
        for (int i = 0; i < n; i++)
            pending_events.push_back('{kinds[i], vals[i], i == n - 1});
        last_count = n;
        if (n > 0) begin
            first_kind = kinds[0];
            first_value = vals[0];
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            no_gap_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    task automatic send_sample(input logic up, input logic down, input logic mute,
                               input logic [STAMP_W-1:0] stamp);
        int gap;
        sample_valid <= 1'b1;
        up_level <= up;
        down_level <= down;
        mute_level <= mute;
        now_ms <= stamp;
        do
            @(posedge clk);
        while (sample_stall);
        predict_events(up, down, mute, stamp);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every queued event is out, then let the core go quiet.
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_apply(input logic [DELAY_W-1:0] d, input logic [LEVEL_W-1:0] lo,
                             input logic [LEVEL_W-1:0] hi);
        wr_en <= 1'b1;
        wr_index <= CFG_PRESS_DELAY;
        wr_data <= d;
        @(posedge clk);
        wr_index <= CFG_LOUDEST;
        wr_data <= DELAY_W'(lo);
        @(posedge clk);
        wr_index <= CFG_QUIETEST;
        wr_data <= DELAY_W'(hi);
        @(posedge clk);
        // unmapped index must leave all registers alone
        wr_index <= CFG_UNUSED;
        wr_data <= DELAY_W'($urandom);
        @(posedge clk);
        wr_en <= 1'b0;
        delay_ms = d;
        loud_lim = lo;
        quiet_lim = hi;
    endtask

    function automatic logic [STAMP_W-1:0] next_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return STAMP_W'($urandom);
        if (r < 4)
            return STAMP_W'($urandom_range(0, 2));
        return STAMP_W'($urandom_range(0, 2 * int'(delay_ms) + 2));
    endfunction

    task automatic send_later(input logic up, input logic down, input logic mute);
        now_t = now_t + next_step();
        send_sample(up, down, mute, now_t);
    endtask

    // One press, hold and release of the buttons, or a burst of noise.
    task automatic run_sequence();
        int   pick;
        int   holds;
        logic up_p;
        logic down_p;
        pick = $urandom_range(0, 9);
        holds = $urandom_range(0, 4);
        if (pick < 7) begin
            up_p = (pick < 3) || (pick == 6);
            down_p = (pick >= 3);
            send_later(!up_p, !down_p, 1'b1);
            repeat (holds) send_later(!up_p, !down_p, 1'b1);
            if (pick == 6 && $urandom_range(0, 1) == 1)
                send_later(1'b1, 1'b0, 1'b1);
            send_later(1'b1, 1'b1, 1'b1);
        end
        else if (pick == 7) begin
            send_later(1'b1, 1'b1, 1'b0);
            repeat (holds) send_later(1'(!$urandom_range(0, 3)), 1'b1, 1'b0);
            send_later(1'b1, 1'b1, 1'b1);
        end
        else begin
            repeat (holds + 1)
                send_later(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
        end
    endtask

    // drop a random stall on the event side, in short and long bursts
    always @(posedge clk)
    begin
        if (run_left > 0) begin
            run_left--;
            event_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            event_stall <= 1'b1;
        end
        else begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 3);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
            event_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && event_valid && !event_stall) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("event kind %0d value %0d with none pending",
                                          event_kind, event_value));
            end
            else begin
                want = pending_events.pop_front();
                if (event_kind != want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              event_kind, want.kind));
                if (event_value != want.value)
                    report_mismatch($sformatf("event_value %0d, want %0d",
                                              event_value, want.value));
                if (last_event != want.is_last)
                    report_mismatch($sformatf("last_event %0b, want %0b",
                                              last_event, want.is_last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        up_level = 1'b1;
        down_level = 1'b1;
        mute_level = 1'b1;
        now_ms = '0;
        event_stall = 1'b0;
        wr_en = 1'b0;
        wr_index = CFG_PRESS_DELAY;
        wr_data = '0;
        mismatches = 0;
        samples_sent = 0;
        events_seen = 0;
        cycles = 0;
        no_gap_left = 0;
        stall_left = 0;
        run_left = 0;
        held_up = 1'b1;
        held_down = 1'b1;
        held_mute = 1'b1;
        repeat_stamp = '0;
        auto_up = 1'b0;
        auto_down = 1'b0;
        level = QUIETEST_RST;
        muted = 1'b0;
        holdoff_on = 1'b0;
        holdoff_stamp = '0;
        delay_ms = PRESS_DELAY_RST;
        loud_lim = LOUDEST_RST;
        quiet_lim = QUIETEST_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].up, directed_rows[i].down,
                        directed_rows[i].mute, directed_rows[i].stamp);
            if (directed_rows[i].typed) begin
                if (last_count != int'(directed_rows[i].count))
                    report_mismatch($sformatf("row %0d: %0d events, want %0d",
                                              i, last_count, directed_rows[i].count));
                else if (last_count > 0 && (first_kind != directed_rows[i].kind ||
                         first_value != directed_rows[i].value))
                    report_mismatch($sformatf("row %0d: first event %0d/%0d", i,
                                              first_kind, first_value));
            end
        end
        now_t = 32'd0;
        settle();

        for (int p = 0; p < PHASES; p++) begin
            int phase_start;
            case (p)
                0: cfg_apply(DELAY_W'($urandom_range(1, 12)), 7'd0, 7'd127);
                1: cfg_apply(16'hFFFF, 7'd127, 7'd127);
                2: cfg_apply(16'd0, LEVEL_W'($urandom_range(0, 60)),
                             LEVEL_W'($urandom_range(61, 127)));
                default: cfg_apply(DELAY_W'($urandom_range(0, 400)),
                                   LEVEL_W'($urandom_range(0, 127)),
                                   LEVEL_W'($urandom_range(0, 127)));
            endcase
            phase_start = samples_sent;
            while (samples_sent - phase_start < RANDOM_PER_PHASE) begin
                run_sequence();
                if ($urandom_range(0, 29) == 0)
                    settle();
            end
            settle();
        end

        $display("Sent %0d button samples over %0d register settings, %0d events returned",
                 samples_sent, PHASES + 1, events_seen);
        $display("Settings reached delay 0 and 65535 and limits 0 and 127; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
